/* rtl/core/bfs_pkg.sv */
// ----------------------------------------------------------------------------
// bfs_pkg
// shared types and constants of the fit scale address generator
// ----------------------------------------------------------------------------
package bfs_pkg;

  localparam int DIM_W   = 13;  // image and box sizes, 0..8191
  localparam int POS_W   = 12;  // screen and target positions
  localparam int ADDR_W  = 26;  // byte addresses and sizes
  localparam int FIT_DW  = 25;  // size product for the fit divisions
  localparam int SRC_DW  = 24;  // position product for the source divisions

  localparam logic [1:0] BYTES_PER_PIXEL = 2'd3;
  localparam logic [2:0] ROW_ALIGN       = 3'd4;
  localparam logic [1:0] HALF_SHIFT      = 2'd2;  // split of the free space

  typedef enum logic [2:0] {
    CFG_IMAGE_WIDTH  = 3'd0,
    CFG_IMAGE_HEIGHT = 3'd1,
    CFG_BOX_LEFT     = 3'd2,
    CFG_BOX_TOP      = 3'd3,
    CFG_BOX_WIDTH    = 3'd4,
    CFG_BOX_HEIGHT   = 3'd5,
    CFG_PIXEL_OFFSET = 3'd6,
    CFG_DATA_SIZE    = 3'd7
  } cfg_index_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_OVERRUN  = 2'd2,
    ST_OUTSIDE  = 2'd3
  } status_t;

  // data riding beside the fit divisions
  typedef struct packed {
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
  } fit_side_t;

  // data riding beside the source divisions
  typedef struct packed {
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    logic [DIM_W-1:0] tw;
    logic [DIM_W-1:0] th;
    logic             outside;
  } src_side_t;

endpackage

/* rtl/core/bmp_fit_scale_address_generator_unit.sv */
// ----------------------------------------------------------------------------
// bmp_fit_scale_address_generator_unit
// aspect-fit nearest-neighbor address generator for padded bottom-up bmp
// ----------------------------------------------------------------------------
// throughput: one beat per cycle while no result beat is stalled, set by the
// two division cell rows
// (25 cells for the fit sizes, 24 cells for the source position)
// a stalled result beat freezes the whole pipeline
// rst (synchronous) clears all valid bits and the configuration registers to zero
// ----------------------------------------------------------------------------
module bmp_fit_scale_address_generator_unit
  import bfs_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 1920,
  parameter int SCREEN_HEIGHT = 1080
) (
  input  logic              clk,
  input  logic              rst,
  // configuration
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [ADDR_W-1:0] cfg_data,
  // input channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [POS_W-1:0]  out_col,
  input  logic [POS_W-1:0]  out_row,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        status,
  output logic [ADDR_W-1:0] src_byte_addr,
  output logic [POS_W-1:0]  screen_col,
  output logic [POS_W-1:0]  screen_row,
  output logic [DIM_W-1:0]  fit_width,
  output logic [DIM_W-1:0]  fit_height
);

  localparam logic [DIM_W:0] SCR_W = (DIM_W+1)'(SCREEN_WIDTH);
  localparam logic [DIM_W:0] SCR_H = (DIM_W+1)'(SCREEN_HEIGHT);

  // configuration registers
  logic [DIM_W-1:0]  image_width;
  logic [DIM_W-1:0]  image_height;
  logic [POS_W-1:0]  box_left;
  logic [POS_W-1:0]  box_top;
  logic [DIM_W-1:0]  box_width;
  logic [DIM_W-1:0]  box_height;
  logic [ADDR_W-1:0] pixel_offset;
  logic [ADDR_W-1:0] data_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= '0;
      image_height <= '0;
      box_left     <= '0;
      box_top      <= '0;
      box_width    <= '0;
      box_height   <= '0;
      pixel_offset <= '0;
      data_size    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_IMAGE_WIDTH:  image_width  <= cfg_data[DIM_W-1:0];
        CFG_IMAGE_HEIGHT: image_height <= cfg_data[DIM_W-1:0];
        CFG_BOX_LEFT:     box_left     <= cfg_data[POS_W-1:0];
        CFG_BOX_TOP:      box_top      <= cfg_data[POS_W-1:0];
        CFG_BOX_WIDTH:    box_width    <= cfg_data[DIM_W-1:0];
        CFG_BOX_HEIGHT:   box_height   <= cfg_data[DIM_W-1:0];
        CFG_PIXEL_OFFSET: pixel_offset <= cfg_data;
        CFG_DATA_SIZE:    data_size    <= cfg_data;
      endcase
    end
  end

  // registers' geometry; user must hold them while beats are in flight, unchecked
  logic             geo_invalid;
  logic [DIM_W-1:0] bw_c;
  logic [DIM_W-1:0] bh_c;
  logic [DIM_W:0]   right_edge;
  logic [DIM_W:0]   bottom_edge;
  logic [DIM_W+2:0] iw_bytes;
  logic [DIM_W+2:0] stride;

  always_comb begin
    geo_invalid = (image_width == '0) || (image_height == '0) ||
                  (box_width == '0) || (box_height == '0) ||
                  ({2'b0, box_left} >= SCR_W) || ({2'b0, box_top} >= SCR_H) ||
                  (pixel_offset >= data_size);
    right_edge  = {2'b0, box_left} + {1'b0, box_width};
    bottom_edge = {2'b0, box_top} + {1'b0, box_height};
    // box clipped to the screen
    bw_c = (right_edge > SCR_W) ? DIM_W'(SCR_W - {2'b0, box_left}) : box_width;
    bh_c = (bottom_edge > SCR_H) ? DIM_W'(SCR_H - {2'b0, box_top}) : box_height;
    // padded row length in bytes
    iw_bytes = {2'b0, image_width} * (DIM_W+3)'(BYTES_PER_PIXEL);
    stride   = (iw_bytes + (DIM_W+3)'(ROW_ALIGN - 3'd1)) & ~(DIM_W+3)'(ROW_ALIGN - 3'd1);
  end

  // one enable moves every stage
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = out_valid && out_stall;

  // stage 0: size products for the fit
  logic              v0;
  logic [POS_W-1:0]  col0;
  logic [POS_W-1:0]  row0;
  logic [FIT_DW-1:0] hw_prod0;
  logic [FIT_DW-1:0] wh_prod0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      col0     <= out_col;
      row0     <= out_row;
      hw_prod0 <= FIT_DW'(image_height) * FIT_DW'(bw_c);
      wh_prod0 <= FIT_DW'(image_width) * FIT_DW'(bh_c);
    end
  end

  // fit divisions: height from width, width from height
  fit_side_t               fit_side_in;
  fit_side_t               fit_side_out;
  logic                    fit_v;
  logic [1:0][FIT_DW-1:0]  fit_quo;

  assign fit_side_in = '{col: col0, row: row0};

  bfs_div_chain #(.DW(FIT_DW), .VW(DIM_W), .SW($bits(fit_side_t))) u_fit_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .v_in     (v0),
    .dvd_in   ({wh_prod0, hw_prod0}),
    .dvs_in   ({image_height, image_width}),
    .side_in  (fit_side_in),
    .v_out    (fit_v),
    .quo_out  (fit_quo),
    .side_out (fit_side_out)
  );

  // stage 1: fitted size, outside check, position products
  logic [DIM_W-1:0]  tw_next;
  logic [DIM_W-1:0]  th_next;

  always_comb begin
    tw_next = image_width;
    th_next = image_height;
    if ((image_width > bw_c) || (image_height > bh_c)) begin
      if (fit_quo[0] <= FIT_DW'(bh_c)) begin
        tw_next = bw_c;
        th_next = DIM_W'(fit_quo[0]);
      end else begin
        tw_next = DIM_W'(fit_quo[1]);
        th_next = bh_c;
      end
    end
    // at least one pixel each way
    if (tw_next == '0) tw_next = DIM_W'(1);
    if (th_next == '0) th_next = DIM_W'(1);
  end

  logic              v1;
  src_side_t         side1;
  logic [SRC_DW-1:0] x_prod1;
  logic [SRC_DW-1:0] y_prod1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= fit_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side1.col     <= fit_side_out.col;
      side1.row     <= fit_side_out.row;
      side1.tw      <= tw_next;
      side1.th      <= th_next;
      side1.outside <= ({1'b0, fit_side_out.col} >= tw_next) ||
                       ({1'b0, fit_side_out.row} >= th_next);
      x_prod1 <= SRC_DW'(fit_side_out.col) * SRC_DW'(image_width);
      y_prod1 <= SRC_DW'(fit_side_out.row) * SRC_DW'(image_height);
    end
  end

  // source divisions: nearest source column and row
  src_side_t               src_side_out;
  logic                    src_v;
  logic [1:0][SRC_DW-1:0]  src_quo;

  bfs_div_chain #(.DW(SRC_DW), .VW(DIM_W), .SW($bits(src_side_t))) u_src_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .v_in     (v1),
    .dvd_in   ({y_prod1, x_prod1}),
    .dvs_in   ({side1.th, side1.tw}),
    .side_in  (side1),
    .v_out    (src_v),
    .quo_out  (src_quo),
    .side_out (src_side_out)
  );

  // stage 2: bottom-up source row, centered screen position
  logic              v2;
  logic [DIM_W-1:0]  src_x2;
  logic [DIM_W-1:0]  src_y2;
  logic [POS_W-1:0]  sc2;
  logic [POS_W-1:0]  sr2;
  logic [DIM_W-1:0]  tw2;
  logic [DIM_W-1:0]  th2;
  logic              outside2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= src_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      src_x2   <= src_quo[0][DIM_W-1:0];
      src_y2   <= image_height - DIM_W'(1) - src_quo[1][DIM_W-1:0];
      sc2      <= POS_W'({1'b0, box_left} + ((bw_c - src_side_out.tw) >> 1)
                         + {1'b0, src_side_out.col});
      sr2      <= POS_W'({1'b0, box_top} + ((bh_c - src_side_out.th) >> 1)
                         + {1'b0, src_side_out.row});
      tw2      <= src_side_out.tw;
      th2      <= src_side_out.th;
      outside2 <= src_side_out.outside;
    end
  end

  // stage 3: row and column byte offsets
  logic              v3;
  logic [27:0]       row_off3;
  logic [DIM_W+1:0]  col_off3;
  logic [POS_W-1:0]  sc3;
  logic [POS_W-1:0]  sr3;
  logic [DIM_W-1:0]  tw3;
  logic [DIM_W-1:0]  th3;
  logic              outside3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      row_off3 <= 28'(src_y2) * 28'(stride);
      col_off3 <= {1'b0, src_x2, 1'b0} + {2'b0, src_x2};
      sc3      <= sc2;
      sr3      <= sr2;
      tw3      <= tw2;
      th3      <= th2;
      outside3 <= outside2;
    end
  end

  // stage 4: bound check, status priority, result register
  logic [29:0] row_start;
  logic [29:0] row_end;
  logic        overrun;

  always_comb begin
    row_start = {4'b0, pixel_offset} + {2'b0, row_off3};
    row_end   = row_start + {14'b0, iw_bytes};
    overrun   = row_end > {4'b0, data_size};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      status        <= ST_OK;
      src_byte_addr <= ADDR_W'(row_start + {15'b0, col_off3});
      screen_col    <= sc3;
      screen_row    <= sr3;
      fit_width     <= tw3;
      fit_height    <= th3;
      priority if (geo_invalid) begin
        status        <= ST_INVALID;
        src_byte_addr <= '0;
        screen_col    <= '0;
        screen_row    <= '0;
        fit_width     <= '0;
        fit_height    <= '0;
      end else if (outside3) begin
        status        <= ST_OUTSIDE;
        src_byte_addr <= '0;
        screen_col    <= '0;
        screen_row    <= '0;
      end else if (overrun) begin
        status        <= ST_OVERRUN;
        src_byte_addr <= '0;
      end
    end
  end

endmodule

/* rtl/core/bfs_div_cell.sv */
// ----------------------------------------------------------------------------
// bfs_div_cell
// one restoring division step for two lanes, registered
// ----------------------------------------------------------------------------
module bfs_div_cell #(
  parameter int DW = 25,
  parameter int VW = 13,
  parameter int SW = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   v_in,
  input  logic [1:0][DW-1:0]     dq_in,
  input  logic [1:0][VW-1:0]     rem_in,
  input  logic [1:0][VW-1:0]     dvs_in,
  input  logic [SW-1:0]          side_in,
  output logic                   v_out,
  output logic [1:0][DW-1:0]     dq_out,
  output logic [1:0][VW-1:0]     rem_out,
  output logic [1:0][VW-1:0]     dvs_out,
  output logic [SW-1:0]          side_out
);

  logic [1:0][VW:0]   trial;
  logic [1:0]         ge;
  logic [1:0][DW-1:0] dq_next;
  logic [1:0][VW-1:0] rem_next;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      trial[i]    = {rem_in[i], dq_in[i][DW-1]};
      ge[i]       = trial[i] >= {1'b0, dvs_in[i]};
      rem_next[i] = ge[i] ? VW'(trial[i] - {1'b0, dvs_in[i]}) : VW'(trial[i]);
      dq_next[i]  = {dq_in[i][DW-2:0], ge[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (en) begin
      v_out <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dq_out   <= dq_next;
      rem_out  <= rem_next;
      dvs_out  <= dvs_in;
      side_out <= side_in;
    end
  end

endmodule

/* rtl/core/bfs_div_chain.sv */
// ----------------------------------------------------------------------------
// bfs_div_chain
// row of division cells, one quotient bit per cell, two lanes
// ----------------------------------------------------------------------------
module bfs_div_chain #(
  parameter int DW = 25,
  parameter int VW = 13,
  parameter int SW = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   v_in,
  input  logic [1:0][DW-1:0]     dvd_in,
  input  logic [1:0][VW-1:0]     dvs_in,
  input  logic [SW-1:0]          side_in,
  output logic                   v_out,
  output logic [1:0][DW-1:0]     quo_out,
  output logic [SW-1:0]          side_out
);

  logic [DW:0]                 v;
  logic [DW:0][1:0][DW-1:0]    dq;
  logic [DW:0][1:0][VW-1:0]    rem;
  logic [DW:0][1:0][VW-1:0]    dvs;
  logic [DW:0][SW-1:0]         side;

  assign v[0]    = v_in;
  assign dq[0]   = dvd_in;
  assign rem[0]  = '0;
  assign dvs[0]  = dvs_in;
  assign side[0] = side_in;

  for (genvar k = 0; k < DW; k++) begin : g_cell
    bfs_div_cell #(.DW(DW), .VW(VW), .SW(SW)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .v_in     (v[k]),
      .dq_in    (dq[k]),
      .rem_in   (rem[k]),
      .dvs_in   (dvs[k]),
      .side_in  (side[k]),
      .v_out    (v[k+1]),
      .dq_out   (dq[k+1]),
      .rem_out  (rem[k+1]),
      .dvs_out  (dvs[k+1]),
      .side_out (side[k+1])
    );
  end

  assign v_out    = v[DW];
  assign quo_out  = dq[DW];
  assign side_out = side[DW];

endmodule

/* tb/fit_scale_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fit_scale_checker
// watches the input and result channels of the fit scale address generator,
// computes the expected beat for each accepted input and compares in order
// ----------------------------------------------------------------------------
module fit_scale_checker
  import bfs_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 1920,
  parameter int SCREEN_HEIGHT = 1080
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [ADDR_W-1:0] cfg_data,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [POS_W-1:0]  out_col,
  input  logic [POS_W-1:0]  out_row,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [1:0]        status,
  input  logic [ADDR_W-1:0] src_byte_addr,
  input  logic [POS_W-1:0]  screen_col,
  input  logic [POS_W-1:0]  screen_row,
  input  logic [DIM_W-1:0]  fit_width,
  input  logic [DIM_W-1:0]  fit_height,
  output int                errors,
  output int                pending
);

  typedef struct packed {
    status_t           st;
    logic [ADDR_W-1:0] addr;
    logic [POS_W-1:0]  sc;
    logic [POS_W-1:0]  sr;
    logic [DIM_W-1:0]  fw;
    logic [DIM_W-1:0]  fh;
  } pixel_beat_t;

  logic [DIM_W-1:0]  img_w, img_h, bx_w, bx_h;
  logic [POS_W-1:0]  bx_l, bx_t;
  logic [ADDR_W-1:0] pix_off, dsize;
  pixel_beat_t       expected_beats[$];

  function automatic pixel_beat_t map_pixel(longint col, longint row);
    pixel_beat_t r;
    longint bw, bh, tw, th, hw, wh, ox, oy, stride, sx, sy, rs;
    r = '0;
    if (img_w == 0 || img_h == 0 || bx_w == 0 || bx_h == 0 ||
        bx_l >= SCREEN_WIDTH || bx_t >= SCREEN_HEIGHT || pix_off >= dsize) begin
      r.st = ST_INVALID;
      return r;
    end
    bw = bx_w;
    bh = bx_h;
    if (bx_l + bw > SCREEN_WIDTH) bw = SCREEN_WIDTH - bx_l;
    if (bx_t + bh > SCREEN_HEIGHT) bh = SCREEN_HEIGHT - bx_t;
    tw = img_w;
    th = img_h;
    if (tw > bw || th > bh) begin
      hw = (img_h * bw) / img_w;
      wh = (img_w * bh) / img_h;
      if (hw <= bh) begin
        tw = bw;
        th = hw;
      end else begin
        tw = wh;
        th = bh;
      end
    end
    if (tw == 0) tw = 1;
    if (th == 0) th = 1;
    r.fw = tw;
    r.fh = th;
    if (col >= tw || row >= th) begin
      r.st = ST_OUTSIDE;
      return r;
    end
    ox = bx_l + (bw - tw) / 2;
    oy = bx_t + (bh - th) / 2;
    r.sc = ox + col;
    r.sr = oy + row;
    stride = ((img_w * 3 + 3) / 4) * 4;
    sx = (col * img_w) / tw;
    sy = img_h - 1 - ((row * img_h) / th);
    rs = pix_off + sy * stride;
    if (rs + img_w * 3 > dsize) begin
      r.st = ST_OVERRUN;
      return r;
    end
    r.st = ST_OK;
    r.addr = rs + sx * 3;
    return r;
  endfunction

  assign pending = expected_beats.size();

  always @(posedge clk) begin
    pixel_beat_t exp_b;
    if (rst) begin
      img_w <= '0; img_h <= '0; bx_l <= '0; bx_t <= '0;
      bx_w <= '0; bx_h <= '0; pix_off <= '0; dsize <= '0;
      errors = 0;
      expected_beats.delete();
    end else begin
      if (in_valid && !in_stall)
        expected_beats.push_back(map_pixel(out_col, out_row));
      if (out_valid && !out_stall) begin
        if (expected_beats.size() == 0) begin
          errors++;
          $display("%0t: unexpected result beat, actual status %0d", $time, status);
        end else begin
          exp_b = expected_beats.pop_front();
          if (status !== exp_b.st || src_byte_addr !== exp_b.addr ||
              screen_col !== exp_b.sc || screen_row !== exp_b.sr ||
              fit_width !== exp_b.fw || fit_height !== exp_b.fh) begin
            errors++;
            $display("%0t: mismatch expected st %0d addr %0d col %0d row %0d fw %0d fh %0d",
                     $time, exp_b.st, exp_b.addr, exp_b.sc, exp_b.sr, exp_b.fw, exp_b.fh);
            $display("%0t:          actual st %0d addr %0d col %0d row %0d fw %0d fh %0d",
                     $time, status, src_byte_addr, screen_col, screen_row,
                     fit_width, fit_height);
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index_t'(cfg_index))
          CFG_IMAGE_WIDTH:  img_w <= cfg_data[DIM_W-1:0];
          CFG_IMAGE_HEIGHT: img_h <= cfg_data[DIM_W-1:0];
          CFG_BOX_LEFT:     bx_l <= cfg_data[POS_W-1:0];
          CFG_BOX_TOP:      bx_t <= cfg_data[POS_W-1:0];
          CFG_BOX_WIDTH:    bx_w <= cfg_data[DIM_W-1:0];
          CFG_BOX_HEIGHT:   bx_h <= cfg_data[DIM_W-1:0];
          CFG_PIXEL_OFFSET: pix_off <= cfg_data;
          CFG_DATA_SIZE:    dsize <= cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives geometry settings and pixel positions into the fit scale address
// generator with random idling on both sides; the checker gives the verdict
// ----------------------------------------------------------------------------
module testbench;
  import bfs_pkg::*;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [2:0]        cfg_index = '0;
  logic [ADDR_W-1:0] cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [POS_W-1:0]  out_col = '0;
  logic [POS_W-1:0]  out_row = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [1:0]        status;
  logic [ADDR_W-1:0] src_byte_addr;
  logic [POS_W-1:0]  screen_col, screen_row;
  logic [DIM_W-1:0]  fit_width, fit_height;
  int                errors, pending;
  bit                calm;  // no idling on either side while set

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bmp_fit_scale_address_generator_unit u_top (.*);
  fit_scale_checker u_chk (.*);

  // result side stalls with a chance of 11 in a hundred unless calm is set
  always @(posedge clk)
    out_stall <= !calm && ($urandom_range(99) < 11);

  task automatic write_reg(cfg_index_t idx, int unsigned val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= ADDR_W'(val);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // all eight registers; block must be drained first
  task automatic set_geometry(int unsigned iw, int unsigned ih, int unsigned bl,
                              int unsigned bt, int unsigned bw, int unsigned bh,
                              int unsigned po, int unsigned ds);
    write_reg(CFG_IMAGE_WIDTH, iw);
    write_reg(CFG_IMAGE_HEIGHT, ih);
    write_reg(CFG_BOX_LEFT, bl);
    write_reg(CFG_BOX_TOP, bt);
    write_reg(CFG_BOX_WIDTH, bw);
    write_reg(CFG_BOX_HEIGHT, bh);
    write_reg(CFG_PIXEL_OFFSET, po);
    write_reg(CFG_DATA_SIZE, ds);
  endtask

  // one input beat, with random idling ahead of it unless calm is set
  task automatic send_pixel(int unsigned col, int unsigned row);
    while (!calm && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    out_col  <= POS_W'(col);
    out_row  <= POS_W'(row);
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // mostly inside the fitted rectangle, sometimes anywhere
  task automatic random_pixels(int n, int unsigned tw, int unsigned th);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) < 8)
        send_pixel($urandom_range(tw > 0 ? tw - 1 : 0), $urandom_range(th > 0 ? th - 1 : 0));
      else
        send_pixel($urandom_range(4095), $urandom_range(4095));
    end
    drain();
  endtask

  initial begin
    int unsigned iw, ih, ds;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset values: every field invalid
    send_pixel(0, 0);
    send_pixel(4095, 4095);
    drain();

    // small image fits as-is, exact data size, then one byte short (still no overrun, row padding is not checked)
    set_geometry(5, 4, 100, 50, 300, 200, 54, 54 + 16 * 4);
    send_pixel(0, 0);
    send_pixel(4, 3);
    send_pixel(5, 0);
    send_pixel(0, 4);
    drain();
    write_reg(CFG_DATA_SIZE, 54 + 16 * 4 - 1);
    send_pixel(0, 0);
    send_pixel(4, 3);
    drain();

    // largest image, box clipped at screen corner, shrink to 1 pixel
    set_geometry(4096, 4096, 1919, 1079, 4096, 4096, 0, 67108863);
    send_pixel(0, 0);
    send_pixel(1, 0);
    drain();
    // wide image into full screen, huge data
    set_geometry(4096, 1, 0, 0, 1920, 1080, 67108862, 67108863);
    send_pixel(0, 0);
    send_pixel(1919, 0);
    drain();
    // invalid corners: off-screen origin, zero box, offset at data size
    set_geometry(10, 10, 1920, 0, 10, 10, 0, 1000);
    send_pixel(0, 0);
    drain();
    set_geometry(10, 10, 0, 4095, 10, 10, 0, 1000);
    send_pixel(0, 0);
    drain();
    set_geometry(10, 10, 0, 0, 0, 10, 0, 1000);
    send_pixel(0, 0);
    drain();
    set_geometry(10, 10, 4095, 0, 10, 10, 1000, 1000);
    send_pixel(0, 0);
    drain();
    // tall image, height limited
    set_geometry(100, 4096, 10, 10, 500, 600, 3, 4096 * 300 + 3);
    send_pixel(0, 0);
    send_pixel(14, 599);
    drain();

    // random settings, long calm stretch in the middle
    for (int ph = 0; ph < 24; ph++) begin
      calm = (ph >= 10 && ph < 13);
      iw = ($urandom_range(9) == 0) ? $urandom_range(4096) : $urandom_range(1, 64);
      ih = ($urandom_range(9) == 0) ? $urandom_range(4096) : $urandom_range(1, 64);
      ds = ((iw * 3 + 3) / 4) * 4 * ih;
      ds = ds + $urandom_range(200) - ($urandom_range(3) == 0 ? $urandom_range(ds) : 0);
      set_geometry(iw, ih,
                   ($urandom_range(9) == 0) ? $urandom_range(4095) : $urandom_range(1919),
                   ($urandom_range(9) == 0) ? $urandom_range(4095) : $urandom_range(1079),
                   $urandom_range(1, 4096) >> $urandom_range(6),
                   $urandom_range(1, 4096) >> $urandom_range(6),
                   $urandom_range(100), ds + 100);
      random_pixels(31, iw < 64 ? iw : 64, ih < 64 ? ih : 64);
    end
    calm = 0;

    repeat (70) @(posedge clk);
    if (errors == 0)
      $display("bmp_fit_scale_address_generator_unit test passed");
    else
      $display("bmp_fit_scale_address_generator_unit test failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("bmp_fit_scale_address_generator_unit test failed");
    $finish;
  end

endmodule

/* files.f */
rtl/core/bfs_pkg.sv
rtl/core/bfs_div_cell.sv
rtl/core/bfs_div_chain.sv
rtl/core/bmp_fit_scale_address_generator_unit.sv
tb/fit_scale_checker.sv
tb/testbench.sv
